FILE: rtl/brkg_pkg.sv
// ----------------------------------------------------------------------------
// brkg_pkg
// Shared constants, types and helpers for the block reverse k-group unit.
// ----------------------------------------------------------------------------
`default_nettype none

package brkg_pkg;

  localparam int unsigned MaxGroup = 16;
  localparam int unsigned GrpW     = $clog2(MaxGroup);
  localparam int unsigned CntW     = $clog2(MaxGroup + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register index of group_size on the configuration port.
  localparam logic RegGroupSize = 1'b0;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StSend
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // input transfer this cycle
    logic rd;    // issue a store read for the current result
    logic step;  // current result taken, move to the next one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;  // the offered input closes a burst
    logic fin;   // the current result is the last of its burst
  } sts_t;

  // Effective group size: zero acts as one, large values saturate.
  function automatic logic [CntW-1:0] eff_size(input logic [CfgW-1:0] gs);
    int unsigned g;
    logic [CntW-1:0] k;
    g = 32'(gs);
    if (g == 0) begin
      k = CntW'(1);
    end else if (g > MaxGroup) begin
      k = CntW'(MaxGroup);
    end else begin
      k = CntW'(g);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/brkg_ram.sv
// ----------------------------------------------------------------------------
// brkg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brkg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/brkg_ctrl.sv
// ----------------------------------------------------------------------------
// brkg_ctrl
// Controller: accepts values, then walks the burst one read and send at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module brkg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire brkg_pkg::sts_t sts_i,
  output brkg_pkg::cmd_t     cmd_o
);

  brkg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brkg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      brkg_pkg::StIdle: begin
        if (in_valid_i && sts_i.emit) begin
          state_d = brkg_pkg::StRead;
        end
      end
      brkg_pkg::StRead: begin
        state_d = brkg_pkg::StSend;
      end
      brkg_pkg::StSend: begin
        if (out_ready_i) begin
          state_d = sts_i.fin ? brkg_pkg::StIdle : brkg_pkg::StRead;
        end
      end
      default: begin
        state_d = brkg_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      brkg_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      brkg_pkg::StRead: begin
        cmd_o.rd = 1'b1;
      end
      brkg_pkg::StSend: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i && !sts_i.fin;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/brkg_dpath.sv
// ----------------------------------------------------------------------------
// brkg_dpath
// Datapath: group store, fill count and the burst read address generator.
// ----------------------------------------------------------------------------
`default_nettype none

module brkg_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire brkg_pkg::cmd_t               cmd_i,
  output brkg_pkg::sts_t                    sts_o,
  input  wire logic [brkg_pkg::CfgW-1:0]    group_size_i,
  input  wire logic [brkg_pkg::DataW-1:0]   in_value_i,
  input  wire logic                         in_last_i,
  output logic      [brkg_pkg::DataW-1:0]   out_value_o,
  output logic                              burst_end_o,
  output logic                              list_end_o
);

  logic [brkg_pkg::GrpW-1:0] fill_q, fill_d;
  logic [brkg_pkg::GrpW-1:0] idx_q, idx_d;
  logic [brkg_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      rev_q, rev_d;
  logic                      last_q, last_d;

  logic [brkg_pkg::CntW-1:0] k;
  logic [brkg_pkg::CntW-1:0] n_in;
  logic                      full;
  logic [brkg_pkg::CntW-1:0] rev_addr;
  logic [brkg_pkg::GrpW-1:0] raddr;
  logic                      fin;

  assign k    = brkg_pkg::eff_size(group_size_i);
  assign n_in = {1'b0, fill_q} + brkg_pkg::CntW'(1);
  assign full = (n_in >= k);

  // Reversed bursts read from the newest entry down.
  assign rev_addr = cnt_q - brkg_pkg::CntW'(1) - {1'b0, idx_q};
  assign raddr    = rev_q ? rev_addr[brkg_pkg::GrpW-1:0] : idx_q;
  assign fin      = (({1'b0, idx_q} + brkg_pkg::CntW'(1)) == cnt_q);

  assign sts_o.emit = full || in_last_i;
  assign sts_o.fin  = fin;

  always_comb begin
    fill_d = fill_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    rev_d  = rev_q;
    last_d = last_q;
    if (cmd_i.take) begin
      if (sts_o.emit) begin
        fill_d = '0;
        idx_d  = '0;
        cnt_d  = n_in;
        rev_d  = full;
        last_d = in_last_i;
      end else begin
        fill_d = fill_q + brkg_pkg::GrpW'(1);
      end
    end else if (cmd_i.step) begin
      idx_d = idx_q + brkg_pkg::GrpW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idx_q  <= '0;
      cnt_q  <= '0;
      rev_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      rev_q  <= rev_d;
      last_q <= last_d;
    end
  end

  brkg_ram #(
    .Width (brkg_pkg::DataW),
    .Depth (brkg_pkg::MaxGroup)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take),
    .waddr_i (fill_q),
    .wdata_i (in_value_i),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (out_value_o)
  );

  assign burst_end_o = fin;
  assign list_end_o  = fin && last_q;

  // A closing input always restarts the group and the burst walk.
  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && sts_o.emit) |=> (fill_q == '0 && idx_q == '0 && cnt_q != '0))
    else $error("burst did not restart after a closing input");

  // Reads stay inside the current burst.
  a_read_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> ({1'b0, idx_q} < cnt_q))
    else $error("store read beyond the burst length");

  // A non-closing input grows the group by exactly one.
  a_fill_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && !sts_o.emit) |=> (fill_q == $past(fill_q) + brkg_pkg::GrpW'(1)))
    else $error("fill count did not advance");

endmodule

`default_nettype wire

FILE: rtl/block_reverse_k_group_unit.sv
// ----------------------------------------------------------------------------
// block_reverse_k_group_unit
// Reverses a stream of signed values in groups of a programmable size.
// ----------------------------------------------------------------------------
// A value that closes a burst is stored; each result of the burst then takes a
//   registered store read (StRead) and waits in StSend until it is taken.
// Inputs that close no burst are taken back to back while idle; a burst holds
//   the input side until its last result is taken.
// Reset: asynchronous, active low; group empty, group_size = 1. The group
//   store is not cleared, since every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module block_reverse_k_group_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input stream.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [brkg_pkg::DataW-1:0]     s_axis_tdata,  // [31:0] in_value
  input  wire logic                           s_axis_tlast,  // in_last
  // Result stream.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [brkg_pkg::DataW-1:0]     m_axis_tdata,  // [31:0] out_value
  output logic                                m_axis_tlast,  // burst_end
  output logic      [0:0]                     m_axis_tuser,  // [0] list_end
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [brkg_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [brkg_pkg::ApbDataW-1:0]  pwdata,
  output logic      [brkg_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready
);

  brkg_pkg::cmd_t cmd;
  brkg_pkg::sts_t sts;

  logic [brkg_pkg::CfgW-1:0] group_size_q, group_size_d;
  logic                      reg_hit;
  logic                      list_end;

  // Registers sit on 32-bit words; bit 2 of the byte address picks the word,
  // and only the first word holds a register.
  assign reg_hit = (paddr[2] == brkg_pkg::RegGroupSize);
  assign pready  = 1'b1;

  always_comb begin
    group_size_d = group_size_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      group_size_d = pwdata[brkg_pkg::CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= brkg_pkg::CfgW'(1);
    end else begin
      group_size_q <= group_size_d;
    end
  end

  assign prdata = reg_hit ? {{(brkg_pkg::ApbDataW - brkg_pkg::CfgW){1'b0}}, group_size_q}
                          : '0;

  // The controller takes a value while idle. When the value fills a group or
  // ends the sequence, it walks the burst: one store read, then one output
  // transfer, per result.
  brkg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the group, decides whether a burst is reversed (full
  // group) or kept in order (short tail at the end of a sequence) and marks
  // the final result of each burst.
  brkg_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .group_size_i (group_size_q),
    .in_value_i   (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_value_o  (m_axis_tdata),
    .burst_end_o  (m_axis_tlast),
    .list_end_o   (list_end)
  );

  assign m_axis_tuser = list_end;

endmodule

`default_nettype wire

FILE: verif/brkg_order_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brkg_order_check
// Watches the stream and configuration ports of the reverse k-group unit,
// predicts the reordered values and compares every result transfer.
// ----------------------------------------------------------------------------

module brkg_order_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [brkg_pkg::DataW-1:0]     s_tdata_i,
  input  logic                           s_tlast_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [brkg_pkg::DataW-1:0]     m_tdata_i,
  input  logic                           m_tlast_i,
  input  logic [0:0]                     m_tuser_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [brkg_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [brkg_pkg::ApbDataW-1:0]  pwdata_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);

  typedef struct packed {
    logic [brkg_pkg::DataW-1:0] value;
    logic                       burst_end;
    logic                       list_end;
  } reordered_t;

  reordered_t                 reordered_q[$];
  logic [brkg_pkg::DataW-1:0] group_vals[brkg_pkg::MaxGroup];
  int unsigned                group_fill;
  logic [brkg_pkg::CfgW-1:0]  group_size;

  // Size actually used for a group: zero acts as one, large values clip.
  function automatic int unsigned span_of(input logic [brkg_pkg::CfgW-1:0] gs);
    int unsigned g;
    g = 32'(gs);
    if (g == 0) begin
      return 1;
    end
    if (g > brkg_pkg::MaxGroup) begin
      return brkg_pkg::MaxGroup;
    end
    return g;
  endfunction

  // Adds one value to the group and queues the burst it closes, if any.
  task automatic collect_value(input logic [brkg_pkg::DataW-1:0] v, input logic last);
    int unsigned k;
    int unsigned n;
    reordered_t  r;
    k = span_of(group_size);
    group_vals[group_fill] = v;
    n = group_fill + 1;
    if (n >= k || last) begin
      for (int unsigned i = 0; i < n; i++) begin
        r.value     = (n >= k) ? group_vals[n-1-i] : group_vals[i];
        r.burst_end = (i == n - 1);
        r.list_end  = r.burst_end && last;
        reordered_q.push_back(r);
      end
      group_fill = 0;
    end else begin
      group_fill = n;
    end
  endtask

  task automatic check_result(input reordered_t got);
    reordered_t want;
    if (reordered_q.size() == 0) begin
      $error("unexpected result transfer: out_value %0d", $signed(got.value));
      mismatch_count_o++;
    end else begin
      want = reordered_q.pop_front();
      if (got.value !== want.value) begin
        $error("out_value: expected %0d, actual %0d",
               $signed(want.value), $signed(got.value));
        mismatch_count_o++;
      end
      if (got.burst_end !== want.burst_end) begin
        $error("burst_end: expected %0d, actual %0d", want.burst_end, got.burst_end);
        mismatch_count_o++;
      end
      if (got.list_end !== want.list_end) begin
        $error("list_end: expected %0d, actual %0d", want.list_end, got.list_end);
        mismatch_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reordered_q.delete();
      group_fill       = 0;
      group_size       = brkg_pkg::CfgW'(1);
      mismatch_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[brkg_pkg::ApbAddrW-1:2] == brkg_pkg::RegGroupSize) begin
        group_size = pwdata_i[brkg_pkg::CfgW-1:0];
      end
      if (s_tvalid_i && s_tready_i) begin
        collect_value(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_result({m_tdata_i, m_tlast_i, m_tuser_i[0]});
      end
    end
    pending_o = reordered_q.size();
  end

endmodule

FILE: verif/tb_block_reverse_k_group_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_reverse_k_group_unit
// Drives value sequences and group-size writes into the reverse k-group unit
// with random idling on both streams; a separate checker predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------

module tb_block_reverse_k_group_unit;

  localparam int ResetCycles = 11;
  localparam int TotalItems  = 430;
  // From this many accepted inputs on, neither side idles any more.
  localparam int QuietFrom   = 400;
  // Cycles let pass after the last result before the block counts as idle.
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 500000;

  localparam logic [brkg_pkg::ApbAddrW-1:0] AddrGroupSize = {brkg_pkg::RegGroupSize, 2'b00};
  // Register index one is not mapped; a write there must change nothing.
  localparam logic [brkg_pkg::ApbAddrW-1:0] AddrUnmapped  = {~brkg_pkg::RegGroupSize, 2'b00};

  localparam logic [brkg_pkg::DataW-1:0] MinValue = 32'h8000_0000;
  localparam logic [brkg_pkg::DataW-1:0] MaxValue = 32'h7FFF_FFFF;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          s_tvalid  = 1'b0;
  logic [brkg_pkg::DataW-1:0]    s_tdata   = '0;
  logic                          s_tlast   = 1'b0;
  logic                          m_tready  = 1'b0;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [brkg_pkg::ApbAddrW-1:0] paddr     = '0;
  logic [brkg_pkg::ApbDataW-1:0] pwdata    = '0;

  logic                          s_tready;
  logic                          m_tvalid;
  logic [brkg_pkg::DataW-1:0]    m_tdata;
  logic                          m_tlast;
  logic [0:0]                    m_tuser;
  logic [brkg_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  int mismatch_count;
  int pending;

  // Stimulus bookkeeping used by the sender, the receiver and the watchdog processes.
  int items_sent = 0;
  bit quiet      = 1'b0;
  bit gaps_on    = 1'b1;
  int cycles     = 0;

  block_reverse_k_group_unit uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [31:0] in_value
    .s_axis_tlast  (s_tlast),   // in_last
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [31:0] out_value
    .m_axis_tlast  (m_tlast),   // burst_end
    .m_axis_tuser  (m_tuser),   // [0] list_end
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  brkg_order_check u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tlast_i        (s_tlast),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tlast_i        (m_tlast),
    .m_tuser_i        (m_tuser),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a result that never shows up ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: ready runs of random length broken by stalls of random
  // length. Long ready runs give stretches without any stall. Once the run
  // has gone quiet, ready simply stays high.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // One register write: a setup phase, then an access phase held until
  // pready. psel and penable then drop so back-to-back writes stay well formed.
  task automatic write_reg(input logic [brkg_pkg::ApbAddrW-1:0] addr,
                           input logic [brkg_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one value and returns after its transfer. tvalid stays high so
  // that the next value can follow in the very next cycle; sometimes the
  // sender idles for a random stretch instead.
  task automatic push_value(input logic [brkg_pkg::DataW-1:0] v, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (items_sent >= QuietFrom) begin
      quiet = 1'b1;
    end
    if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Holds the sender off until every predicted result has arrived, then
  // lets the drain time pass before anything else happens.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Random content with the corner values showing up often.
  function automatic logic [brkg_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return MinValue;
      1:       return MaxValue;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // A run of values; when close is set, the final one carries tlast.
  task automatic send_sequence(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++) begin
      push_value(pick_value(), close && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned                   sz;
    int unsigned                   span;
    int unsigned                   len;
    logic [brkg_pkg::ApbDataW-1:0] word;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- Directed part ----------------
    // A write to the unmapped register leaves the reset size of one, so the
    // extremes of the value range pass straight through.
    write_reg(AddrUnmapped, 32'd4);
    push_value(MinValue, 1'b0);
    push_value(MaxValue, 1'b1);
    wait_drained();

    // Size zero behaves like size one.
    write_reg(AddrGroupSize, 32'd0);
    push_value('1, 1'b1);
    wait_drained();

    // Size three: one full group comes out reversed, then the tail of one
    // value closes the sequence in its own order.
    write_reg(AddrGroupSize, 32'd3);
    push_value(32'd10, 1'b0);
    push_value(32'd20, 1'b0);
    push_value(32'd30, 1'b0);
    push_value(32'd40, 1'b1);
    wait_drained();

    // Size change in the middle of a group: three values wait under size
    // eight, then the size drops to two and the next value flushes all four
    // in reversed order without marking the end of the list.
    write_reg(AddrGroupSize, 32'd8);
    send_sequence(3, 1'b0);
    wait_drained();
    write_reg(AddrGroupSize, 32'd2);
    push_value(pick_value(), 1'b0);
    push_value(pick_value(), 1'b1);
    wait_drained();

    // A size above the store depth clips to sixteen; the sequence ends
    // exactly on a full group, so the reversed burst also ends the list.
    write_reg(AddrGroupSize, 32'd17);
    send_sequence(16, 1'b1);

    // ---------------- Random part ----------------
    // Each phase sets a new size while the block is idle and then sends a
    // few well-formed sequences. Now and then a sequence is left open, so
    // the following size change lands on a partly filled group.
    while (items_sent < TotalItems) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0:       sz = 0;
        1:       sz = 1;
        2:       sz = brkg_pkg::MaxGroup;
        3:       sz = $urandom_range(brkg_pkg::MaxGroup + 1, 31);
        default: sz = $urandom_range(2, brkg_pkg::MaxGroup - 1);
      endcase
      span = (sz == 0) ? 1 : ((sz > brkg_pkg::MaxGroup) ? brkg_pkg::MaxGroup : sz);
      // Bits above the register field carry noise; only the field counts.
      word                     = $urandom();
      word[brkg_pkg::CfgW-1:0] = brkg_pkg::CfgW'(sz);
      write_reg(AddrGroupSize, word);
      gaps_on = ($urandom_range(0, 3) != 0);

      repeat ($urandom_range(1, 4)) begin
        // Half the sequences are sized to end exactly on a group boundary.
        if ($urandom_range(0, 1) == 1) begin
          len = span * $urandom_range(1, 3);
        end else begin
          len = $urandom_range(1, 3 * span);
        end
        send_sequence(len, 1'b1);
        // Occasionally the sender waits for every pending result.
        if ($urandom_range(0, 7) == 0) begin
          wait_drained();
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        send_sequence($urandom_range(1, span), 1'b0);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/brkg_pkg.sv
rtl/brkg_ram.sv
rtl/brkg_ctrl.sv
rtl/brkg_dpath.sv
rtl/block_reverse_k_group_unit.sv
verif/brkg_order_check.sv
verif/tb_block_reverse_k_group_unit.sv
